// ----- src/carrier_beat_planner_assert.svh -----
// Assertion macros for the carrier beat planner; they sample clk and rst_n of the caller.
`ifndef CARRIER_BEAT_PLANNER_ASSERT_SVH
`define CARRIER_BEAT_PLANNER_ASSERT_SVH
`ifndef SYNTH
`define CBP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define CBP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CBP_ASSERT(lbl, prop, msg)
`define CBP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- src/cbp_pkg.sv -----
// Shared types and constants of the carrier beat planner.
package cbp_pkg;

    localparam int NUM_WHEELS  = 8;
    localparam int WHEEL_SLOTS = 8;
    localparam int BEATS       = 3;

    typedef logic [15:0] steps_t;
    typedef logic [7:0]  count_t;

    typedef enum logic [2:0] {
        CFG_STEPS_60 = 3'd0,
        CFG_STEPS_30 = 3'd1,
        CFG_STEPS_28 = 3'd2,
        CFG_STEPS_90 = 3'd3,
        CFG_STEPS_32 = 3'd4
    } cfg_idx_t;

    localparam steps_t RST_STEPS_60 = 16'd1600;
    localparam steps_t RST_STEPS_30 = 16'd800;
    localparam steps_t RST_STEPS_28 = 16'd747;
    localparam steps_t RST_STEPS_90 = 16'd2400;
    localparam steps_t RST_STEPS_32 = 16'd853;

    localparam logic [1:0] BEAT_FIRST = 2'd0;
    localparam logic [1:0] BEAT_LAST  = 2'd2;

    typedef struct packed {
        steps_t s60;
        steps_t s30;
        steps_t s28;
        steps_t s90;
        steps_t s32;
    } cfg_t;

    typedef struct packed {
        logic [BEATS-1:0][WHEEL_SLOTS-1:0][15:0] steps;
        logic [BEATS-1:0]                        motion;
    } plan_t;

endpackage

// ----- src/cbp_load_if.sv -----
// Load channel: eight wheel item counts with valid/ready.
interface cbp_load_if;
    logic   valid;
    logic   ready;
    logic [7:0] count_wheel_1;
    logic [7:0] count_wheel_2;
    logic [7:0] count_wheel_3;
    logic [7:0] count_wheel_4;
    logic [7:0] count_wheel_5;
    logic [7:0] count_wheel_6;
    logic [7:0] count_wheel_7;
    logic [7:0] count_wheel_8;

    modport source (
        output valid, count_wheel_1, count_wheel_2, count_wheel_3, count_wheel_4,
               count_wheel_5, count_wheel_6, count_wheel_7, count_wheel_8,
        input  ready
    );
    modport sink (
        input  valid, count_wheel_1, count_wheel_2, count_wheel_3, count_wheel_4,
               count_wheel_5, count_wheel_6, count_wheel_7, count_wheel_8,
        output ready
    );
endinterface

// ----- src/cbp_beat_if.sv -----
// Beat channel: one beat of per-wheel step counts with valid/ready.
interface cbp_beat_if;
    logic        valid;
    logic        ready;
    logic [1:0]  beat_number;
    logic [15:0] steps_wheel_1;
    logic [15:0] steps_wheel_2;
    logic [15:0] steps_wheel_3;
    logic [15:0] steps_wheel_4;
    logic [15:0] steps_wheel_5;
    logic [15:0] steps_wheel_6;
    logic [15:0] steps_wheel_7;
    logic [15:0] steps_wheel_8;
    logic        beat_has_motion;
    logic        last_beat;

    modport source (
        output valid, beat_number, steps_wheel_1, steps_wheel_2, steps_wheel_3,
               steps_wheel_4, steps_wheel_5, steps_wheel_6, steps_wheel_7,
               steps_wheel_8, beat_has_motion, last_beat,
        input  ready
    );
    modport sink (
        input  valid, beat_number, steps_wheel_1, steps_wheel_2, steps_wheel_3,
               steps_wheel_4, steps_wheel_5, steps_wheel_6, steps_wheel_7,
               steps_wheel_8, beat_has_motion, last_beat,
        output ready
    );
endinterface

// ----- src/cbp_cfg_if.sv -----
// Configuration write channel: register index and data with valid/ready.
interface cbp_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/cbp_planner.sv -----
// Pairing and move planning for one load: three beats of step counts and next states.
module cbp_planner (
    input  cbp_pkg::count_t [cbp_pkg::WHEEL_SLOTS-1:0] counts,
    input  logic [cbp_pkg::WHEEL_SLOTS-1:0]            state,
    input  cbp_pkg::cfg_t                              cfg,
    output cbp_pkg::plan_t                             plan,
    output logic [cbp_pkg::WHEEL_SLOTS-1:0]            state_next
);
    localparam int S = cbp_pkg::WHEEL_SLOTS;

    logic [S-1:0] live;
    logic [S-1:0] nz;
    logic [S-1:0] one;
    logic [S-1:0] rb;
    logic [S-1:0] loaded;
    logic [S-1:0] donor;
    logic [S-1:0] free;
    logic [S-1:0] pair;
    logic [S-1:0] go;
    logic [S-1:0] g_single;
    logic [S-1:0] g_over;
    logic [S-1:0] g_reb;
    logic [S-1:0] r_sr;
    logic [S-1:0] r_ov;

    always_comb
    begin
        for (int i = 0; i < S; i++)
        begin
            live[i] = (i < cbp_pkg::NUM_WHEELS);
            nz[i]   = live[i] && (counts[i] != 8'd0);
            one[i]  = (counts[i] == 8'd1);
        end
    end

    assign rb     = state & live;
    assign loaded = ~rb & nz;
    assign donor  = loaded | rb;
    assign free   = ~rb & ~nz;
    // Wheel 1 pairs with the outlet; others need a free neighbor and an empty wheel beyond it.
    assign pair   = {free[S-2:0], 1'b1} & {~nz[S-3:0], 2'b11};
    assign go     = donor & pair & live;

    assign g_single = go & loaded & one;
    assign g_over   = go & loaded & ~one;
    assign g_reb    = go & rb;
    // Receiver of wheel i+1; wheel 1's receiver is the outlet and drops out.
    assign r_sr     = (g_single | g_reb) >> 1;
    assign r_ov     = g_over >> 1;

    always_comb
    begin
        plan = '0;
        for (int i = 0; i < S; i++)
        begin
            priority if (g_single[i]) plan.steps[0][i] = cfg.s60;
            else if (g_over[i])       plan.steps[0][i] = cfg.s28;
            else if (g_reb[i])        plan.steps[0][i] = cfg.s32;
            else if (r_sr[i])         plan.steps[0][i] = cfg.s30;
            else                      plan.steps[0][i] = '0;

            priority if (r_sr[i]) plan.steps[1][i] = cfg.s60;
            else if (r_ov[i])     plan.steps[1][i] = cfg.s90;
            else                  plan.steps[1][i] = '0;

            plan.steps[2][i] = (g_single[i] || g_reb[i]) ? cfg.s30 : '0;
        end
        for (int b = 0; b < cbp_pkg::BEATS; b++)
        begin
            plan.motion[b] = |plan.steps[b];
        end
    end

    assign state_next = live & ((state & ~(go | r_sr | r_ov)) | g_over);

endmodule

// ----- src/carrier_beat_planner.sv -----
// Top level of the carrier beat planner: input register, planner, beat output register.
//
// Each accepted load carries the item counts of the eight carrier wheels and
// produces three beat transactions, beat_number 0, 1 and 2, the last one
// flagged by last_beat. The load is captured in an input register; once the
// output register is empty or its last beat leaves, the planner pairs donors
// with receivers from the counts and the reborn-pending bits, the three beats
// are loaded into the output register and the new wheel states are committed
// at that same edge. The first beat is offered from the output register. The
// output register sends one beat per cycle while the sink is ready, and each
// load holds the single output register for its three beats. The next load is
// taken while beats are still going out. Configuration writes are always
// accepted and take effect for loads planned after the write; indexes beyond
// the five step registers are dropped.
module carrier_beat_planner (
    input  logic              clk,
    input  logic              rst_n,
    cbp_load_if.sink          load,
    cbp_beat_if.source        beat,
    cbp_cfg_if.sink           cfg
);
    localparam int S = cbp_pkg::WHEEL_SLOTS;

    // configuration registers
    cbp_pkg::cfg_t cfg_reg;

    // input register
    logic                              in_valid_reg;
    cbp_pkg::count_t [S-1:0]           counts_reg;
    cbp_pkg::count_t [S-1:0]           counts_next;

    // wheel state: 1 = reborn-pending
    logic [S-1:0]                      state_reg;
    logic [S-1:0]                      state_next;

    // beat output register
    logic                              plan_valid_reg;
    logic                              plan_valid_next;
    cbp_pkg::plan_t                    plan_reg;
    cbp_pkg::plan_t                    plan_next;
    logic [1:0]                        beat_reg;
    logic [1:0]                        beat_next;

    logic                              load_take;
    logic                              beat_take;
    logic                              last_take;
    logic                              move;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.s60 <= cbp_pkg::RST_STEPS_60;
            cfg_reg.s30 <= cbp_pkg::RST_STEPS_30;
            cfg_reg.s28 <= cbp_pkg::RST_STEPS_28;
            cfg_reg.s90 <= cbp_pkg::RST_STEPS_90;
            cfg_reg.s32 <= cbp_pkg::RST_STEPS_32;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                cbp_pkg::CFG_STEPS_60: cfg_reg.s60 <= cfg.data;
                cbp_pkg::CFG_STEPS_30: cfg_reg.s30 <= cfg.data;
                cbp_pkg::CFG_STEPS_28: cfg_reg.s28 <= cfg.data;
                cbp_pkg::CFG_STEPS_90: cfg_reg.s90 <= cfg.data;
                cbp_pkg::CFG_STEPS_32: cfg_reg.s32 <= cfg.data;
                default: ;  // unknown register: drop the write
            endcase
        end
    end

    // Handshake bookkeeping: move the held load into the output register once
    // the output register is empty or its last beat leaves this cycle.
    assign beat_take = plan_valid_reg && beat.ready;
    assign last_take = beat_take && (beat_reg == cbp_pkg::BEAT_LAST);
    assign move      = in_valid_reg && (!plan_valid_reg || last_take);
    assign load.ready = !in_valid_reg || move;
    assign load_take = load.valid && load.ready;

    assign counts_next[0] = load.count_wheel_1;
    assign counts_next[1] = load.count_wheel_2;
    assign counts_next[2] = load.count_wheel_3;
    assign counts_next[3] = load.count_wheel_4;
    assign counts_next[4] = load.count_wheel_5;
    assign counts_next[5] = load.count_wheel_6;
    assign counts_next[6] = load.count_wheel_7;
    assign counts_next[7] = load.count_wheel_8;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= load_take || (in_valid_reg && !move);
        end
    end

    // Payload: hold until replaced by a new transaction.
    always_ff @(posedge clk)
    begin
        if (load_take)
        begin
            counts_reg <= counts_next;
        end
    end

    cbp_planner u_planner (
        .counts     (counts_reg),
        .state      (state_reg),
        .cfg        (cfg_reg),
        .plan       (plan_next),
        .state_next (state_next)
    );

    always_comb
    begin
        priority if (move)
        begin
            plan_valid_next = 1'b1;
            beat_next       = cbp_pkg::BEAT_FIRST;
        end
        else if (beat_take)
        begin
            plan_valid_next = !last_take;
            beat_next       = last_take ? cbp_pkg::BEAT_FIRST : beat_reg + 2'd1;
        end
        else
        begin
            plan_valid_next = plan_valid_reg;
            beat_next       = beat_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plan_valid_reg <= 1'b0;
            beat_reg       <= cbp_pkg::BEAT_FIRST;
            state_reg      <= '0;
        end
        else
        begin
            plan_valid_reg <= plan_valid_next;
            beat_reg       <= beat_next;
            // Commit the wheel states together with the plan that caused them.
            if (move)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            plan_reg <= plan_next;
        end
    end

    // Drive the current beat from the output register.
    assign beat.valid           = plan_valid_reg;
    assign beat.beat_number     = beat_reg;
    assign beat.steps_wheel_1   = plan_reg.steps[beat_reg][0];
    assign beat.steps_wheel_2   = plan_reg.steps[beat_reg][1];
    assign beat.steps_wheel_3   = plan_reg.steps[beat_reg][2];
    assign beat.steps_wheel_4   = plan_reg.steps[beat_reg][3];
    assign beat.steps_wheel_5   = plan_reg.steps[beat_reg][4];
    assign beat.steps_wheel_6   = plan_reg.steps[beat_reg][5];
    assign beat.steps_wheel_7   = plan_reg.steps[beat_reg][6];
    assign beat.steps_wheel_8   = plan_reg.steps[beat_reg][7];
    assign beat.beat_has_motion = plan_reg.motion[beat_reg];
    assign beat.last_beat       = (beat_reg == cbp_pkg::BEAT_LAST);

`include "carrier_beat_planner_assert.svh"

    // Wheel states change only when a load is planned.
    `CBP_ASSERT_NEXT(a_state_hold, !move, $stable(state_reg), "wheel state changed without a plan")
    // A taken beat that is not the last is followed by the next beat of the same load.
    `CBP_ASSERT_NEXT(a_beat_advance, beat_take && !last_take, plan_valid_reg && (beat_reg == $past(beat_reg) + 2'd1), "beat sequence broken")
    // A held load is not overwritten while the output register is still busy.
    `CBP_ASSERT(a_no_overrun, (in_valid_reg && plan_valid_reg && !last_take) |-> !load.ready, "load accepted over a held load")

endmodule
